// File: rtl/akf1d_pkg.sv
`timescale 1ns / 1ps
package akf1d_pkg;

  localparam int DEFAULT_WINDOW_DEPTH = 16;
  localparam int MIN_FILL = 3;

  localparam logic [31:0] ONE_Q16 = 32'd65536;
  localparam logic [16:0] GAIN_ONE = 17'd65536;
  localparam int GAIN_STEPS = 17;

  // Squared window entries fit in 48 bits (|entry| < 2^24).
  localparam int SQ_W = 48;
  localparam int ENTRY_W = 26;
  localparam int INNOV_W = 34;

  localparam logic [31:0] PROCESS_NOISE_RST = 32'd66;
  localparam logic [31:0] INITIAL_NOISE_RST = 32'd65536;
  localparam logic [31:0] NOISE_FLOOR_RST = 32'd655;
  localparam logic [31:0] NOISE_CEILING_RST = 32'd6553600;
  localparam logic signed [15:0] INITIAL_ESTIMATE_RST = 16'sd0;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_NOISE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NOISE_FLOOR = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NOISE_CEILING = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_ESTIMATE = 3'd4;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_RESET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_UPDATE,
    ST_SQUARE,
    ST_WINDOW,
    ST_MEAN,
    ST_DONE
  } state_t;

endpackage

// File: rtl/adaptive_kalman_filter_1d_core.sv
`timescale 1ns / 1ps
// Sequence: a filter transaction runs the gain division (skipped when the
//   denominator is zero), the update, square and window steps, then the
//   mean-square division once 3 innovations are held, and presents the result.
// Throughput: one transaction at a time; a reset goes straight to the result.
// The shared restoring divider (one quotient bit per cycle) sets the rate.
// Reset: synchronous active-low rst_n restores registers and filter state.
module adaptive_kalman_filter_1d_core #(
  parameter int WINDOW_DEPTH = akf1d_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [akf1d_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic signed [15:0]                in_sample_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                out_filtered_value,
  output logic [16:0]                       out_current_gain,
  output logic [31:0]                       out_noise_estimate
);

  // Derived widths: window index, fill count, sum of squares, divider count.
  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = akf1d_pkg::SQ_W + $clog2(WINDOW_DEPTH) + 1;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
  localparam logic [FILL_W-1:0] FILL_MIN = FILL_W'(akf1d_pkg::MIN_FILL);

  // Configuration registers. The initial estimate only applies at hardware
  // reset, where it is back at its reset value, so writes to it are dropped.
  logic [31:0] process_noise_r, initial_noise_r, noise_floor_r, noise_ceiling_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      process_noise_r <= akf1d_pkg::PROCESS_NOISE_RST;
      initial_noise_r <= akf1d_pkg::INITIAL_NOISE_RST;
      noise_floor_r <= akf1d_pkg::NOISE_FLOOR_RST;
      noise_ceiling_r <= akf1d_pkg::NOISE_CEILING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        akf1d_pkg::REG_PROCESS_NOISE: process_noise_r <= cfg_data;
        akf1d_pkg::REG_INITIAL_NOISE: initial_noise_r <= cfg_data;
        akf1d_pkg::REG_NOISE_FLOOR: noise_floor_r <= cfg_data;
        akf1d_pkg::REG_NOISE_CEILING: noise_ceiling_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Filter state.
  akf1d_pkg::state_t state_r, state_nxt;
  logic signed [31:0] est_r, est_nxt;
  logic [31:0] cov_r, cov_nxt;
  logic [31:0] noise_r, noise_nxt;
  logic [16:0] gain_r, gain_nxt;
  logic [IDX_W-1:0] widx_r, widx_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // Per-transaction work registers.
  logic [31:0] pp_r, pp_nxt;
  logic signed [akf1d_pkg::INNOV_W-1:0] innov_r, innov_nxt;
  logic signed [akf1d_pkg::ENTRY_W-1:0] w_r, w_nxt;
  logic [akf1d_pkg::SQ_W-1:0] sq_new_r, sq_new_nxt, sq_old_r, sq_old_nxt;

  // Shared restoring divider: remainder, quotient shift register, divisor.
  logic [33:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [32:0] dvs_r, dvs_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  logic signed [15:0] out_fv_r, out_fv_nxt;
  logic [16:0] out_gain_r, out_gain_nxt;
  logic [31:0] out_noise_r, out_noise_nxt;

  // Window memory, read at the write index with a registered read.
  logic signed [akf1d_pkg::ENTRY_W-1:0] win_mem [WINDOW_DEPTH];
  logic signed [akf1d_pkg::ENTRY_W-1:0] old_r;
  logic win_we;

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[widx_r] <= w_r;
    end
    old_r <= win_mem[widx_r];
  end

  // Divider step, shared by both divisions.
  logic [33:0] div_trial, div_diff;
  logic div_bit;
  logic [33:0] div_rem_step;
  logic [SUM_W-1:0] div_quo_step;

  always_comb begin
    div_trial = {rem_r[32:0], quo_r[SUM_W-1]};
    div_diff = div_trial - {1'b0, dvs_r};
    div_bit = (div_trial >= {1'b0, dvs_r});
    div_rem_step = div_bit ? div_diff : div_trial;
    div_quo_step = {quo_r[SUM_W-2:0], div_bit};
  end

  // Front-end arithmetic on the arriving sample.
  logic [32:0] pp_sum;
  logic [31:0] pp_sat;
  logic [32:0] s_sum;
  logic [48:0] gain_num;
  logic signed [akf1d_pkg::INNOV_W-1:0] sample_q16;

  always_comb begin
    pp_sum = {1'b0, cov_r} + {1'b0, process_noise_r};
    pp_sat = pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
    s_sum = {1'b0, pp_sat} + {1'b0, noise_r};
    gain_num = {1'b0, pp_sat, 16'd0} + {17'd0, s_sum[32:1]};
    sample_q16 = akf1d_pkg::INNOV_W'($signed({in_sample_value, 8'd0}));
  end

  // Update arithmetic.
  logic signed [51:0] est_prod;
  logic signed [51:0] est_rnd;
  logic [48:0] cov_prod;
  logic [16:0] gain_comp;
  logic signed [akf1d_pkg::INNOV_W:0] w_rnd;
  logic signed [51:0] sq_new_full, sq_old_full;
  logic win_full;
  logic [SUM_W-1:0] sum_upd;
  logic [FILL_W-1:0] fill_upd;
  logic [SUM_W-1:0] mean_q;
  logic [31:0] mean_clamped;
  logic signed [32:0] fv_wide;
  logic signed [15:0] fv_sat;

  always_comb begin
    est_prod = $signed({1'b0, gain_r}) * innov_r;
    est_rnd = (est_prod + 52'sd32768) >>> 16;
    gain_comp = akf1d_pkg::GAIN_ONE - gain_r;
    cov_prod = gain_comp * pp_r;
    w_rnd = ((akf1d_pkg::INNOV_W + 1)'(innov_r) + 35'sd128) >>> 8;
    sq_new_full = w_r * w_r;
    sq_old_full = old_r * old_r;
    win_full = (fill_r == FILL_FULL);
    sum_upd = sum_r - (win_full ? SUM_W'(sq_old_r) : '0) + SUM_W'(sq_new_r);
    fill_upd = win_full ? fill_r : fill_r + 1'b1;
    mean_q = div_quo_step;
    if (mean_q < SUM_W'(noise_floor_r)) begin
      mean_clamped = noise_floor_r;
    end else if (mean_q > SUM_W'(noise_ceiling_r)) begin
      mean_clamped = noise_ceiling_r;
    end else begin
      mean_clamped = mean_q[31:0];
    end
    // Round half up to Q8.8, then saturate.
    fv_wide = ($signed({est_r[31], est_r}) + 33'sd128) >>> 8;
    if (fv_wide > 33'sd32767) begin
      fv_sat = 16'sh7FFF;
    end else if (fv_wide < -33'sd32768) begin
      fv_sat = -16'sh8000;
    end else begin
      fv_sat = fv_wide[15:0];
    end
  end

  // Next-state sequencing.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      akf1d_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == akf1d_pkg::OP_RESET) begin
            state_nxt = akf1d_pkg::ST_DONE;
          end else if (s_sum == 33'd0) begin
            state_nxt = akf1d_pkg::ST_UPDATE;
          end else begin
            state_nxt = akf1d_pkg::ST_GAIN;
          end
        end
      end
      akf1d_pkg::ST_GAIN: begin
        if (dcnt_r == DCNT_W'(1)) begin
          state_nxt = akf1d_pkg::ST_UPDATE;
        end
      end
      akf1d_pkg::ST_UPDATE: state_nxt = akf1d_pkg::ST_SQUARE;
      akf1d_pkg::ST_SQUARE: state_nxt = akf1d_pkg::ST_WINDOW;
      akf1d_pkg::ST_WINDOW: begin
        state_nxt = (fill_upd >= FILL_MIN) ? akf1d_pkg::ST_MEAN : akf1d_pkg::ST_DONE;
      end
      akf1d_pkg::ST_MEAN: begin
        if (dcnt_r == DCNT_W'(1)) begin
          state_nxt = akf1d_pkg::ST_DONE;
        end
      end
      akf1d_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = akf1d_pkg::ST_IDLE;
        end
      end
      default: state_nxt = akf1d_pkg::ST_IDLE;
    endcase
  end

  // Datapath control per state.
  always_comb begin
    in_ready = (state_r == akf1d_pkg::ST_IDLE);
    est_nxt = est_r;
    cov_nxt = cov_r;
    noise_nxt = noise_r;
    gain_nxt = gain_r;
    widx_nxt = widx_r;
    fill_nxt = fill_r;
    sum_nxt = sum_r;
    pp_nxt = pp_r;
    innov_nxt = innov_r;
    w_nxt = w_r;
    sq_new_nxt = sq_new_r;
    sq_old_nxt = sq_old_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    dcnt_nxt = dcnt_r;
    win_we = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_fv_nxt = out_fv_r;
    out_gain_nxt = out_gain_r;
    out_noise_nxt = out_noise_r;

    case (state_r)
      akf1d_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == akf1d_pkg::OP_RESET) begin
            // Reload the filter and empty the window.
            est_nxt = sample_q16[31:0];
            cov_nxt = akf1d_pkg::ONE_Q16;
            noise_nxt = initial_noise_r;
            gain_nxt = '0;
            widx_nxt = '0;
            fill_nxt = '0;
            sum_nxt = '0;
          end else begin
            pp_nxt = pp_sat;
            innov_nxt = sample_q16 - akf1d_pkg::INNOV_W'(est_r);
            if (s_sum == 33'd0) begin
              gain_nxt = akf1d_pkg::GAIN_ONE;
            end else begin
              // Quotient fits 17 bits, so start with the top of the numerator.
              rem_nxt = {2'b00, gain_num[48:17]};
              quo_nxt = {gain_num[16:0], (SUM_W - 17)'(0)};
              dvs_nxt = s_sum;
              dcnt_nxt = DCNT_W'(akf1d_pkg::GAIN_STEPS);
            end
          end
        end
      end
      akf1d_pkg::ST_GAIN: begin
        rem_nxt = div_rem_step;
        quo_nxt = div_quo_step;
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == DCNT_W'(1)) begin
          gain_nxt = div_quo_step[16:0];
        end
      end
      akf1d_pkg::ST_UPDATE: begin
        est_nxt = est_r + est_rnd[31:0];
        cov_nxt = cov_prod[47:16] + {31'd0, cov_prod[15]};
        w_nxt = w_rnd[akf1d_pkg::ENTRY_W-1:0];
      end
      akf1d_pkg::ST_SQUARE: begin
        sq_new_nxt = sq_new_full[akf1d_pkg::SQ_W-1:0];
        sq_old_nxt = sq_old_full[akf1d_pkg::SQ_W-1:0];
      end
      akf1d_pkg::ST_WINDOW: begin
        win_we = 1'b1;
        sum_nxt = sum_upd;
        fill_nxt = fill_upd;
        widx_nxt = (widx_r == IDX_LAST) ? '0 : widx_r + 1'b1;
        rem_nxt = '0;
        quo_nxt = sum_upd;
        dvs_nxt = 33'(fill_upd);
        dcnt_nxt = DCNT_W'(SUM_W);
      end
      akf1d_pkg::ST_MEAN: begin
        rem_nxt = div_rem_step;
        quo_nxt = div_quo_step;
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == DCNT_W'(1)) begin
          noise_nxt = mean_clamped;
        end
      end
      akf1d_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_fv_nxt = fv_sat;
          out_gain_nxt = gain_r;
          out_noise_nxt = noise_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= akf1d_pkg::ST_IDLE;
      est_r <= 32'($signed({akf1d_pkg::INITIAL_ESTIMATE_RST, 8'd0}));
      cov_r <= akf1d_pkg::ONE_Q16;
      noise_r <= akf1d_pkg::INITIAL_NOISE_RST;
      gain_r <= '0;
      widx_r <= '0;
      fill_r <= '0;
      sum_r <= '0;
      dcnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      est_r <= est_nxt;
      cov_r <= cov_nxt;
      noise_r <= noise_nxt;
      gain_r <= gain_nxt;
      widx_r <= widx_nxt;
      fill_r <= fill_nxt;
      sum_r <= sum_nxt;
      dcnt_r <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk) begin
    pp_r <= pp_nxt;
    innov_r <= innov_nxt;
    w_r <= w_nxt;
    sq_new_r <= sq_new_nxt;
    sq_old_r <= sq_old_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    out_fv_r <= out_fv_nxt;
    out_gain_r <= out_gain_nxt;
    out_noise_r <= out_noise_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_filtered_value = out_fv_r;
  assign out_current_gain = out_gain_r;
  assign out_noise_estimate = out_noise_r;

`ifndef SYNTHESIS
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= akf1d_pkg::GAIN_ONE)
    else $error("gain above one");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("window fill count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while busy");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == akf1d_pkg::ST_DONE && state_nxt == akf1d_pkg::ST_IDLE |=> out_valid)
    else $error("result not presented at end of transaction");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  // Drain allowance: extra wait after the last expected result is back.
  localparam int DRAIN_CYCLES = 120;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 255;
  localparam int NUM_PHASES = 6;
  localparam int DEPTH = akf1d_pkg::DEFAULT_WINDOW_DEPTH;
  localparam int IDX_W = akf1d_pkg::CFG_INDEX_W;
  // Index 7 maps to no register; a write there must be dropped.
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    logic signed [15:0] filtered;
    logic [16:0] gain;
    logic [31:0] noise;
  } kf_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic op;
    logic signed [15:0] sample;
    logic [IDX_W-1:0] reg_idx;
    logic [31:0] reg_val;
    bit typed;
    kf_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = akf1d_pkg::OP_FILTER;
  logic signed [15:0] in_sample_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_filtered_value;
  logic [16:0] out_current_gain;
  logic [31:0] out_noise_estimate;

  always #1 clk = ~clk;

  adaptive_kalman_filter_1d_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_sample_value(in_sample_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_filtered_value(out_filtered_value),
    .out_current_gain(out_current_gain),
    .out_noise_estimate(out_noise_estimate)
  );

  // Shadow of the configuration registers.
  logic [31:0] q_noise, r_init, r_floor, r_ceiling;

  // Filter state as the core should hold it.
  logic signed [31:0] kf_est;
  logic [31:0] kf_cov;
  logic [31:0] kf_noise;
  logic [16:0] kf_gain;
  longint kf_window[DEPTH];
  int kf_wr_idx;
  int kf_fill;
  longint kf_sumsq;

  kf_result_t expected_results[$];
  stim_row_t stim_table[$];
  int errors = 0;
  int n_items = 0;
  int n_resets = 0;
  int n_results = 0;
  int n_unity_gain = 0;
  bit hold_request = 0;

  function automatic void shadow_write(logic [IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      akf1d_pkg::REG_PROCESS_NOISE: q_noise = val;
      akf1d_pkg::REG_INITIAL_NOISE: r_init = val;
      akf1d_pkg::REG_NOISE_FLOOR: r_floor = val;
      akf1d_pkg::REG_NOISE_CEILING: r_ceiling = val;
      // The initial estimate only matters at hardware reset.
      akf1d_pkg::REG_INITIAL_ESTIMATE: ;
      default: ;
    endcase
  endfunction

  function automatic void clear_filter(longint est_q16);
    kf_est = 32'(est_q16);
    kf_cov = akf1d_pkg::ONE_Q16;
    kf_noise = r_init;
    kf_gain = '0;
    foreach (kf_window[i]) kf_window[i] = 0;
    kf_wr_idx = 0;
    kf_fill = 0;
    kf_sumsq = 0;
  endfunction

  // Advance the filter state by one transaction and return the result it yields.
  function automatic kf_result_t kalman_update(logic op, logic signed [15:0] smp);
    longint pp, s, innov, w, old, r, fv;
    kf_result_t res;
    if (op == akf1d_pkg::OP_RESET) begin
      clear_filter(longint'(smp) * 256);
    end else begin
      pp = longint'(kf_cov) + longint'(q_noise);
      if (pp > 64'sh0FFFF_FFFF) pp = 64'sh0FFFF_FFFF;
      s = pp + longint'(kf_noise);
      innov = longint'(smp) * 256 - longint'(kf_est);
      if (s == 0) kf_gain = akf1d_pkg::GAIN_ONE;
      else kf_gain = 17'(((pp <<< 16) + (s >>> 1)) / s);
      kf_est = 32'(longint'(kf_est) + ((longint'(kf_gain) * innov + 32768) >>> 16));
      kf_cov = 32'(((65536 - longint'(kf_gain)) * pp + 32768) >>> 16);
      w = (innov + 128) >>> 8;
      if (kf_fill >= DEPTH) begin
        old = kf_window[kf_wr_idx];
        kf_sumsq -= old * old;
      end else begin
        kf_fill++;
      end
      kf_sumsq += w * w;
      kf_window[kf_wr_idx] = w;
      kf_wr_idx = (kf_wr_idx + 1) % DEPTH;
      if (kf_fill >= akf1d_pkg::MIN_FILL) begin
        r = kf_sumsq / kf_fill;
        // With the floor above the ceiling, values below the floor take the floor, all others the ceiling.
        if (r < longint'(r_floor)) r = longint'(r_floor);
        else if (r > longint'(r_ceiling)) r = longint'(r_ceiling);
        kf_noise = 32'(r);
      end
    end
    fv = (longint'(kf_est) + 128) >>> 8;
    if (fv > 32767) fv = 32767;
    if (fv < -32768) fv = -32768;
    res.filtered = 16'(fv);
    res.gain = kf_gain;
    res.noise = kf_noise;
    return res;
  endfunction

  function automatic void add_item(logic op, logic signed [15:0] smp);
    stim_row_t row;
    row = '{ROW_ITEM, op, smp, '0, '0, 1'b0, '{16'sd0, 17'd0, 32'd0}};
    stim_table.push_back(row);
  endfunction

  function automatic void add_typed(logic op, logic signed [15:0] smp,
                                    logic signed [15:0] fv, logic [16:0] k, logic [31:0] r);
    stim_row_t row;
    row = '{ROW_ITEM, op, smp, '0, '0, 1'b1, '{fv, k, r}};
    stim_table.push_back(row);
  endfunction

  function automatic void add_cfg(logic [IDX_W-1:0] idx, logic [31:0] val);
    stim_row_t row;
    row = '{ROW_CFG, akf1d_pkg::OP_FILTER, '0, idx, val, 1'b0, '{16'sd0, 17'd0, 32'd0}};
    stim_table.push_back(row);
  endfunction

  // Offer one transaction after a random gap; keep valid high when there is no gap.
  task automatic send_item(logic op, logic signed [15:0] smp, bit typed, kf_result_t want);
    int gap;
    kf_result_t res;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_sample_value <= smp;
    do @(posedge clk); while (!in_ready);
    res = kalman_update(op, smp);
    if (typed) res = want;
    expected_results.push_back(res);
    n_items++;
    if (op == akf1d_pkg::OP_RESET) n_resets++;
  endtask

  // Hold the input until every expected result is back and the core has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    shadow_write(idx, val);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_all(logic [31:0] q, logic [31:0] ri, logic [31:0] fl,
                             logic [31:0] ce, logic [15:0] ei);
    wait_idle();
    write_reg(akf1d_pkg::REG_PROCESS_NOISE, q);
    write_reg(akf1d_pkg::REG_INITIAL_NOISE, ri);
    write_reg(akf1d_pkg::REG_NOISE_FLOOR, fl);
    write_reg(akf1d_pkg::REG_NOISE_CEILING, ce);
    write_reg(akf1d_pkg::REG_INITIAL_ESTIMATE, {16'd0, ei});
    end_writes();
  endtask

  // Mostly track the estimate with small noise; mix in full-range and extreme samples.
  function automatic logic signed [15:0] draw_sample();
    int pick;
    longint v;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end else if (pick <= 3) begin
      return 16'($urandom);
    end
    v = ((longint'(kf_est) + 128) >>> 8) + $urandom_range(0, 1024) - 512;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_side
    kf_result_t want;
    int stall;
    bit held;
    held = 0;
    forever begin
      if (hold_request && !held) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      n_results++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: filtered_value=%0d", out_filtered_value);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_filtered_value !== want.filtered) begin
          $error("filtered_value: expected %0d, got %0d", want.filtered, out_filtered_value);
          errors++;
        end
        if (out_current_gain !== want.gain) begin
          $error("current_gain: expected %0d, got %0d", want.gain, out_current_gain);
          errors++;
        end
        if (out_noise_estimate !== want.noise) begin
          $error("noise_estimate: expected %0d, got %0d", want.noise, out_noise_estimate);
          errors++;
        end
        if (want.gain == akf1d_pkg::GAIN_ONE) n_unity_gain++;
      end
    end
  end

  initial begin : watchdog
    #4000000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] q, ri, fl, ce;
    logic op;
    shadow_write(akf1d_pkg::REG_PROCESS_NOISE, akf1d_pkg::PROCESS_NOISE_RST);
    shadow_write(akf1d_pkg::REG_INITIAL_NOISE, akf1d_pkg::INITIAL_NOISE_RST);
    shadow_write(akf1d_pkg::REG_NOISE_FLOOR, akf1d_pkg::NOISE_FLOOR_RST);
    shadow_write(akf1d_pkg::REG_NOISE_CEILING, akf1d_pkg::NOISE_CEILING_RST);
    shadow_write(akf1d_pkg::REG_INITIAL_ESTIMATE, {16'd0, akf1d_pkg::INITIAL_ESTIMATE_RST});
    clear_filter(longint'(akf1d_pkg::INITIAL_ESTIMATE_RST) * 256);

    // Directed table: extremes, both operations, unmapped index, zero denominator,
    // floor above ceiling. Typed results only where they are obvious.
    add_typed(akf1d_pkg::OP_RESET, 16'sh7FFF, 16'sh7FFF, 17'd0,
              akf1d_pkg::INITIAL_NOISE_RST);
    add_item(akf1d_pkg::OP_FILTER, 16'sh7FFF);
    add_item(akf1d_pkg::OP_FILTER, 16'sh8000);
    add_item(akf1d_pkg::OP_FILTER, 16'sh8000);
    add_item(akf1d_pkg::OP_FILTER, 16'sh8000);
    add_typed(akf1d_pkg::OP_RESET, 16'sh8000, 16'sh8000, 17'd0,
              akf1d_pkg::INITIAL_NOISE_RST);
    add_item(akf1d_pkg::OP_FILTER, 16'sh0000);
    add_item(akf1d_pkg::OP_FILTER, 16'sh0001);
    add_item(akf1d_pkg::OP_FILTER, 16'shFFFF);
    add_typed(akf1d_pkg::OP_RESET, 16'sh0000, 16'sh0000, 17'd0,
              akf1d_pkg::INITIAL_NOISE_RST);
    add_cfg(REG_UNMAPPED, 32'h1234_5678);
    add_item(akf1d_pkg::OP_FILTER, 16'sh0100);
    add_item(akf1d_pkg::OP_FILTER, 16'shFF00);
    // Zero noise everywhere: gain rounds to one, then P + Q + R hits zero.
    add_cfg(akf1d_pkg::REG_PROCESS_NOISE, 32'd0);
    add_cfg(akf1d_pkg::REG_INITIAL_NOISE, 32'd0);
    add_cfg(akf1d_pkg::REG_NOISE_FLOOR, 32'd0);
    add_cfg(akf1d_pkg::REG_NOISE_CEILING, 32'hFFFF_FFFF);
    add_cfg(akf1d_pkg::REG_INITIAL_ESTIMATE, 32'h0000_FFFF);
    add_typed(akf1d_pkg::OP_RESET, 16'sh0000, 16'sh0000, 17'd0, 32'd0);
    add_typed(akf1d_pkg::OP_FILTER, 16'sh0000, 16'sh0000, akf1d_pkg::GAIN_ONE, 32'd0);
    add_typed(akf1d_pkg::OP_FILTER, 16'sh0000, 16'sh0000, akf1d_pkg::GAIN_ONE, 32'd0);
    add_typed(akf1d_pkg::OP_FILTER, 16'sh0000, 16'sh0000, akf1d_pkg::GAIN_ONE, 32'd0);
    // Floor above ceiling: floor must win for small values.
    add_cfg(akf1d_pkg::REG_PROCESS_NOISE, 32'd66);
    add_cfg(akf1d_pkg::REG_INITIAL_NOISE, 32'd65536);
    add_cfg(akf1d_pkg::REG_NOISE_FLOOR, 32'd1000);
    add_cfg(akf1d_pkg::REG_NOISE_CEILING, 32'd10);
    add_typed(akf1d_pkg::OP_RESET, 16'sh0000, 16'sh0000, 17'd0, 32'd65536);
    add_item(akf1d_pkg::OP_FILTER, 16'sh0000);
    add_item(akf1d_pkg::OP_FILTER, 16'sh0000);
    add_item(akf1d_pkg::OP_FILTER, 16'sh0000);
    add_item(akf1d_pkg::OP_FILTER, 16'sh0300);
    add_item(akf1d_pkg::OP_FILTER, 16'shFD00);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
        end_writes();
      end else begin
        send_item(stim_table[i].op, stim_table[i].sample, stim_table[i].typed,
                  stim_table[i].want);
      end
    end

    // Random phases, each under its own register setting and opened by a reset.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin q = akf1d_pkg::PROCESS_NOISE_RST; ri = akf1d_pkg::INITIAL_NOISE_RST;
                 fl = akf1d_pkg::NOISE_FLOOR_RST; ce = akf1d_pkg::NOISE_CEILING_RST; end
        1: begin q = 32'hFFFF_FFFF; ri = 32'hFFFF_FFFF; fl = 32'd0; ce = 32'hFFFF_FFFF; end
        2: begin q = 32'd0; ri = 32'd0; fl = 32'd0; ce = 32'd0; end
        3: begin q = $urandom; ri = $urandom; fl = $urandom_range(0, 65536);
                 ce = $urandom; end
        4: begin q = $urandom_range(0, 4096); ri = $urandom_range(0, 1 << 20);
                 fl = $urandom_range(1 << 20, 1 << 24); ce = $urandom_range(0, 1 << 16); end
        default: begin q = $urandom_range(0, 1024); ri = $urandom_range(0, 1 << 18);
                 fl = $urandom_range(0, 2048); ce = $urandom_range(1 << 16, 1 << 26); end
      endcase
      program_all(q, ri, fl, ce, 16'($urandom));
      if (p == 2) hold_request = 1;
      send_item(akf1d_pkg::OP_RESET, draw_sample(), 1'b0, '{16'sd0, 17'd0, 32'd0});
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) wait_idle();
        op = ($urandom_range(0, 19) == 0) ? akf1d_pkg::OP_RESET : akf1d_pkg::OP_FILTER;
        send_item(op, draw_sample(), 1'b0, '{16'sd0, 17'd0, 32'd0});
      end
    end

    wait_idle();
    $display("Ran %0d transactions (%0d resets) through %0d register settings.",
             n_items, n_resets, NUM_PHASES + 3);
    $display("Checked %0d results, %0d of them at unity gain.", n_results, n_unity_gain);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
